FILE: rtl/core/ldsfg_pkg.sv
// Package for the LED driver serial frame generator.
// Holds the item, result and job types and the fixed bit positions of the latch window.
// No dependencies.
package ldsfg_pkg;

    localparam int WordBits = 16;
    localparam int ChainW   = 5;

    // First bit clock (0 = MSB) on which the latch line is high.
    localparam logic [3:0] DataLatchFirst   = 4'd15;
    localparam logic [3:0] GlobalLatchFirst = 4'd14;
    localparam logic [3:0] CfgLatchFirst    = 4'd5;
    localparam logic [3:0] LastBitIdx       = 4'd15;

    localparam logic OpGray   = 1'b0;
    localparam logic OpConfig = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [15:0] word;
        logic [5:0]  gain;
    } t_in_item;

    typedef struct packed {
        logic serial_data;
        logic latch_enable;
        logic last_bit;
    } t_result;

    // One classified word waiting to be shifted out.
    typedef struct packed {
        logic [15:0] data;
        logic        latch;
        logic [3:0]  latch_first;
    } t_job;

    // Write side of the job queue.
    typedef struct packed {
        logic push;
        t_job job;
    } t_job_wr;

    // Read side status of the job queue.
    typedef struct packed {
        logic empty;
        t_job job;
    } t_job_rd;

endpackage

FILE: rtl/core/ldsfg_front.sv
// Front end of the LED driver serial frame generator: accepts items, holds the chain
// length register and the chain and group counters, and builds one job per word.
// Depends on ldsfg_pkg.
module ldsfg_front
    import ldsfg_pkg::*;
#(
    parameter int MAX_CHIPS      = 16,
    parameter int CHANNEL_GROUPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [ChainW-1:0] i_cfg_data,
    input  logic              i_push,
    input  t_in_item          i_item,
    input  logic              i_q_full,
    output t_job_wr           o_wr
);

    localparam int CW = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
    localparam int GW = $clog2(CHANNEL_GROUPS);
    localparam logic [7:0]    MaxChips  = 8'(MAX_CHIPS);
    localparam logic [7:0]    MaxLast   = 8'(MAX_CHIPS - 1);
    localparam logic [GW-1:0] LastGroup = GW'(CHANNEL_GROUPS - 1);

    logic [ChainW-1:0] r_chain;
    logic [CW-1:0]     r_chip, n_chip;
    logic [GW-1:0]     r_group, n_group;
    logic [CW-1:0]     r_copy, n_copy;

    logic [7:0] w_cfg_ext;
    logic [7:0] w_last_pos;
    logic       w_accept;
    logic       w_chip_last;
    logic       w_copy_last;
    logic       w_final_group;
    t_job       w_job;

    assign w_accept  = i_push && !i_q_full;
    assign w_cfg_ext = 8'(r_chain);

    // Position of the last chip; a zero length acts as one, an oversize one is clamped.
    always_comb begin
        if (w_cfg_ext == 8'd0) begin
            w_last_pos = 8'd0;
        end else if (w_cfg_ext > MaxChips) begin
            w_last_pos = MaxLast;
        end else begin
            w_last_pos = w_cfg_ext - 8'd1;
        end
    end

    assign w_chip_last   = 8'(r_chip) >= w_last_pos;
    assign w_copy_last   = 8'(r_copy) >= w_last_pos;
    assign w_final_group = r_group >= LastGroup;

    always_comb begin
        n_chip  = r_chip;
        n_group = r_group;
        n_copy  = r_copy;
        w_job   = '0;
        if (i_item.opcode == OpConfig) begin
            w_job.data        = {i_item.word[15:8], i_item.word[7:2] | i_item.gain,
                                 i_item.word[1:0]};
            w_job.latch       = w_copy_last;
            w_job.latch_first = CfgLatchFirst;
            if (w_accept) begin
                n_copy = w_copy_last ? '0 : r_copy + CW'(1);
            end
        end else begin
            w_job.data        = i_item.word;
            w_job.latch       = w_chip_last;
            w_job.latch_first = w_final_group ? GlobalLatchFirst : DataLatchFirst;
            if (w_accept) begin
                if (w_chip_last) begin
                    n_chip  = '0;
                    n_group = w_final_group ? '0 : r_group + GW'(1);
                end else begin
                    n_chip = r_chip + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= ChainW'(1);
            r_chip  <= '0;
            r_group <= '0;
            r_copy  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_chain <= i_cfg_data;
            end
            r_chip  <= n_chip;
            r_group <= n_group;
            r_copy  <= n_copy;
        end
    end

    assign o_wr.push = w_accept;
    assign o_wr.job  = w_job;

`ifndef ASSERT_OFF
    a_group_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_group <= LastGroup)
        else $error("group index beyond last channel group");

    a_gray_leaves_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.opcode == OpGray) |=> $stable(r_copy))
        else $error("grayscale item moved the configuration counter");
`endif

endmodule

FILE: rtl/core/ldsfg_queue.sv
// Two-entry job queue between the front end and the serializer.
// Depends on ldsfg_pkg.
module ldsfg_queue
    import ldsfg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_job_wr i_wr,
    input  logic    i_pop,
    output logic    o_full,
    output t_job_rd o_rd
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count, n_count;

    always_comb begin
        n_count = r_count;
        if (i_wr.push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_wr.push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_wr.push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wr_ptr] <= i_wr.job;
        end
    end

    assign o_full     = r_count == 2'd2;
    assign o_rd.empty = r_count == 2'd0;
    assign o_rd.job   = r_mem[r_rd_ptr];

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("job queue count out of range");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_count == 2'd0))
        else $error("job queue read while empty");
`endif

endmodule

FILE: rtl/core/ldsfg_back.sv
// Serializer of the LED driver serial frame generator: takes one job at a time from
// the queue and presents its sixteen bit clocks, MSB first. Depends on ldsfg_pkg.
module ldsfg_back
    import ldsfg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_job_rd i_rd,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    logic       r_busy;
    t_job       r_job;
    logic [3:0] r_bit;

    logic w_take;
    logic w_done;
    logic w_load;

    assign w_take  = i_pop && r_busy;
    assign w_done  = w_take && (r_bit == LastBitIdx);
    assign w_load  = (!r_busy || w_done) && !i_rd.empty;
    assign o_q_pop = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_bit  <= '0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
                r_bit  <= '0;
            end else if (w_done) begin
                r_busy <= 1'b0;
                r_bit  <= '0;
            end else if (w_take) begin
                r_bit <= r_bit + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_job <= i_rd.job;
        end
    end

    assign o_empty               = !r_busy;
    assign o_result.serial_data  = r_job.data[~r_bit];
    assign o_result.latch_enable = r_job.latch && (r_bit >= r_job.latch_first);
    assign o_result.last_bit     = r_bit == LastBitIdx;

`ifndef ASSERT_OFF
    a_idle_bit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_bit == 4'd0)
        else $error("bit counter moved while idle");

    a_drain_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && i_rd.empty) |=> !r_busy)
        else $error("serializer stayed busy after its last bit");
`endif

endmodule

FILE: rtl/core/led_driver_serial_frame_gen.sv
// Top level of the LED driver serial frame generator.
// Instantiates ldsfg_front, ldsfg_queue and ldsfg_back; uses ldsfg_pkg.
//
// Usage: words for a daisy chain of shift-and-latch LED driver chips enter as items on
// a queue-style input (push/full); an item is taken at a clock edge with push high and
// full low. Each item is a grayscale word (opcode 0) or a configuration word (opcode 1,
// gain ORed in at bit 2). Every item yields sixteen result items, one per serial bit
// clock, MSB first, read from a queue-style output (empty/pop): the oldest result is on
// o_result while empty is low and is taken at an edge with pop high.
// The latch line is raised only on a chain's last word: on the final bit for a data
// latch, on the last two bits of the last channel group for a global latch, and on the
// last eleven bits of a configuration write.
// The chain length register is written through i_cfg_valid/i_cfg_data; o_cfg_ready is
// always high. It should be written only while the block is idle.
// The first bit of an item reaches o_result after the item has been written into the job
// queue and then loaded into the serializer's job register, when the serializer is idle.
// Throughput: one result per cycle while pop is held and work is queued; the single
// serializer and its bit counter shift one word at a time. A
// two-entry job queue lets up to two further items be taken while a word is shifting,
// so a new word follows the previous sixteenth bit without a gap.
// Reset clears all counters, empties the queue and sets the chain length to one.
// When the receiver stalls, the current bit holds and full rises once the queue fills.
module led_driver_serial_frame_gen
    import ldsfg_pkg::*;
#(
    parameter int MAX_CHIPS      = 16,
    parameter int CHANNEL_GROUPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [ChainW-1:0] i_cfg_data,
    input  logic              push,
    output logic              full,
    input  t_in_item          i_item,
    output logic              empty,
    input  logic              pop,
    output t_result           o_result
);

    t_job_wr w_wr;
    t_job_rd w_rd;
    logic    w_q_full;
    logic    w_q_pop;

    // The chain length register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;
    assign full        = w_q_full;

    ldsfg_front #(
        .MAX_CHIPS      (MAX_CHIPS),
        .CHANNEL_GROUPS (CHANNEL_GROUPS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_item      (i_item),
        .i_q_full    (w_q_full),
        .o_wr        (w_wr)
    );

    ldsfg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_rd    (w_rd)
    );

    ldsfg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd     (w_rd),
        .o_q_pop  (w_q_pop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (o_result)
    );

`ifndef ASSERT_OFF
    a_accept_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.push |-> !full)
        else $error("job written into a full queue");
`endif

endmodule
